FILE: src/seg_isect_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package seg_isect_pkg;

	localparam int PORT_WIDTH = 32;

	// control bits that ride along the divider chain
	typedef struct packed {
		logic valid;
		logic hit;
		logic neg_x;
		logic neg_y;
	} ctl_t;

endpackage
`default_nettype wire

FILE: src/seg_isect_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface seg_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] first_start_x;
	logic [31:0] first_start_y;
	logic [31:0] first_end_x;
	logic [31:0] first_end_y;
	logic [31:0] other_start_x;
	logic [31:0] other_start_y;
	logic [31:0] other_end_x;
	logic [31:0] other_end_y;
	logic        infinite_lines;

	modport source (output valid, first_start_x, first_start_y, first_end_x, first_end_y,
		other_start_x, other_start_y, other_end_x, other_end_y, infinite_lines,
		input ready);
	modport sink (input valid, first_start_x, first_start_y, first_end_x, first_end_y,
		other_start_x, other_start_y, other_end_x, other_end_y, infinite_lines,
		output ready);
endinterface

interface seg_out_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [31:0] cross_x;
	logic [31:0] cross_y;

	modport source (output valid, hit, cross_x, cross_y, input ready);
	modport sink (input valid, hit, cross_x, cross_y, output ready);
endinterface
`default_nettype wire

FILE: src/seg_isect_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One restoring-division step for both axes; quotient bits shift into num.
module seg_isect_div_cell #(
	parameter int NW = 100,
	parameter int DW = 66,
	parameter int CW = 32
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   en,
	input  wire seg_isect_pkg::ctl_t ctl_i,
	input  wire [NW-1:0]          num_x_i,
	input  wire [NW-1:0]          num_y_i,
	input  wire [DW-1:0]          rem_x_i,
	input  wire [DW-1:0]          rem_y_i,
	input  wire [DW-1:0]          den_i,
	input  wire [CW-1:0]          start_x_i,
	input  wire [CW-1:0]          start_y_i,
	output seg_isect_pkg::ctl_t   ctl_o,
	output logic [NW-1:0]         num_x_o,
	output logic [NW-1:0]         num_y_o,
	output logic [DW-1:0]         rem_x_o,
	output logic [DW-1:0]         rem_y_o,
	output logic [DW-1:0]         den_o,
	output logic [CW-1:0]         start_x_o,
	output logic [CW-1:0]         start_y_o
);
	import seg_isect_pkg::*;

	logic [DW:0] trial_x, trial_y;
	logic        ge_x, ge_y;
	logic [DW:0] diff_x, diff_y;

	always_comb begin
		trial_x = {rem_x_i, num_x_i[NW-1]};
		trial_y = {rem_y_i, num_y_i[NW-1]};
		ge_x    = trial_x >= {1'b0, den_i};
		ge_y    = trial_y >= {1'b0, den_i};
		diff_x  = ge_x ? (trial_x - {1'b0, den_i}) : trial_x;
		diff_y  = ge_y ? (trial_y - {1'b0, den_i}) : trial_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (en) begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_x_o   <= {num_x_i[NW-2:0], ge_x};
			num_y_o   <= {num_y_i[NW-2:0], ge_y};
			rem_x_o   <= diff_x[DW-1:0];
			rem_y_o   <= diff_y[DW-1:0];
			den_o     <= den_i;
			start_x_o <= start_x_i;
			start_y_o <= start_y_i;
		end
	end
endmodule
`default_nettype wire

FILE: src/seg_isect_sat.sv
`timescale 1ns / 1ps
`default_nettype none
// Sign the quotient, add the start coordinate, clamp to the coordinate range.
module seg_isect_sat #(
	parameter int NW = 100,
	parameter int CW = 32
) (
	input  wire          neg,
	input  wire [NW-1:0] quo,
	input  wire [CW-1:0] start,
	output logic [CW-1:0] coord
);
	localparam int SW = NW + 2;

	logic signed [SW-1:0] q_s, sum, max_v, min_v;

	always_comb begin
		q_s   = neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
		sum   = q_s + $signed({{(SW-CW){start[CW-1]}}, start});
		max_v = $signed({{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}});
		min_v = $signed({{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}});
		if (sum > max_v) begin
			coord = max_v[CW-1:0];
		end else if (sum < min_v) begin
			coord = min_v[CW-1:0];
		end else begin
			coord = sum[CW-1:0];
		end
	end
endmodule
`default_nettype wire

FILE: src/segment_intersection_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Segment intersection core.
// in_ch carries one request per segment pair (two start/end points in signed
// fixed point plus the infinite_lines mode bit); out_ch returns one result per
// request, in order: hit and the intersection point, zero on a miss.
// The pipeline has five front stages (deltas, products, cross terms, range
// test and partial products, numerator sum), one divider cell per quotient
// bit, and the output register. Throughput is one request per cycle while
// the receiver does not stall; the divider chain of 3*COORD_WIDTH+4 cells
// makes up most of the pipeline, each cell retiring one quotient bit for
// both axes.
// The whole pipeline advances together: when the receiver stalls with a
// result held in the output register, in_ch.ready drops and every stage
// holds. Reset clears all valid bits; no result is presented until a
// request has gone through the full pipeline.
// Inputs above COORD_WIDTH bits are ignored; outputs are sign-extended.
module segment_intersection_core #(
	parameter int COORD_WIDTH = 32
) (
	input  wire        clk,
	input  wire        arst_n,
	seg_in_if.sink     in_ch,
	seg_out_if.source  out_ch
);
	import seg_isect_pkg::*;

	localparam int CW  = COORD_WIDTH;
	localparam int DLW = CW + 1;          // delta width
	localparam int PRW = 2 * DLW;         // product width
	localparam int PW  = 2 * CW + 3;      // cross term width
	localparam int DW  = PW - 1;          // |den| width
	localparam int H   = (PW + 1) / 2;    // split of |sn| for partial products
	localparam int NW  = PW + DLW;        // numerator / quotient width

	logic en;

	// ---------------- stage 1: deltas ----------------
	logic                  v_s1, lines_s1;
	logic signed [DLW-1:0] d1x_s1, d1y_s1, d2x_s1, d2y_s1, wx_s1, wy_s1;
	logic [CW-1:0]         ax_s1, ay_s1;

	function automatic logic signed [DLW-1:0] dif(input logic [31:0] a, input logic [31:0] b);
		return $signed({a[CW-1], a[CW-1:0]}) - $signed({b[CW-1], b[CW-1:0]});
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			d1x_s1   <= dif(in_ch.first_end_x, in_ch.first_start_x);
			d1y_s1   <= dif(in_ch.first_end_y, in_ch.first_start_y);
			d2x_s1   <= dif(in_ch.other_end_x, in_ch.other_start_x);
			d2y_s1   <= dif(in_ch.other_end_y, in_ch.other_start_y);
			wx_s1    <= dif(in_ch.first_start_x, in_ch.other_start_x);
			wy_s1    <= dif(in_ch.first_start_y, in_ch.other_start_y);
			ax_s1    <= in_ch.first_start_x[CW-1:0];
			ay_s1    <= in_ch.first_start_y[CW-1:0];
			lines_s1 <= in_ch.infinite_lines;
		end
	end

	// ---------------- stage 2: products ----------------
	logic                  v_s2, lines_s2;
	logic signed [PRW-1:0] pa_s2, pb_s2, pc_s2, pd_s2, pe_s2, pf_s2;
	logic signed [DLW-1:0] d1x_s2, d1y_s2;
	logic [CW-1:0]         ax_s2, ay_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s2    <= d1x_s1 * d2y_s1;
			pb_s2    <= d1y_s1 * d2x_s1;
			pc_s2    <= wy_s1 * d1x_s1;
			pd_s2    <= wx_s1 * d1y_s1;
			pe_s2    <= wy_s1 * d2x_s1;
			pf_s2    <= wx_s1 * d2y_s1;
			d1x_s2   <= d1x_s1;
			d1y_s2   <= d1y_s1;
			ax_s2    <= ax_s1;
			ay_s2    <= ay_s1;
			lines_s2 <= lines_s1;
		end
	end

	// ---------------- stage 3: den, tn, sn ----------------
	logic                  v_s3, lines_s3;
	logic signed [PW-1:0]  den_s3, tn_s3, sn_s3;
	logic signed [DLW-1:0] d1x_s3, d1y_s3;
	logic [CW-1:0]         ax_s3, ay_s3;

	function automatic logic signed [PW-1:0] ext(input logic signed [PRW-1:0] p);
		return $signed({p[PRW-1], p});
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			den_s3   <= ext(pa_s2) - ext(pb_s2);
			tn_s3    <= ext(pc_s2) - ext(pd_s2);
			sn_s3    <= ext(pe_s2) - ext(pf_s2);
			d1x_s3   <= d1x_s2;
			d1y_s3   <= d1y_s2;
			ax_s3    <= ax_s2;
			ay_s3    <= ay_s2;
			lines_s3 <= lines_s2;
		end
	end

	// ---------------- stage 4: range test, partial products ----------------
	logic                 v_s4, hit_s4, negx_s4, negy_s4;
	logic [H+DLW-1:0]     ppxl_s4, ppyl_s4;
	logic [PW-H+DLW-1:0]  ppxh_s4, ppyh_s4;
	logic [DW-1:0]        aden_s4;
	logic [CW-1:0]        ax_s4, ay_s4;

	logic [PW-1:0]  asn, aden;
	logic [DLW-1:0] adx, ady;
	logic           hit_c;

	// n/den within [0,1]
	function automatic logic in_unit(input logic signed [PW-1:0] n,
		input logic signed [PW-1:0] d);
		logic signed [PW-1:0] nn, dd;
		nn = d[PW-1] ? -n : n;
		dd = d[PW-1] ? -d : d;
		return !nn[PW-1] && (nn <= dd);
	endfunction

	always_comb begin
		asn   = sn_s3[PW-1] ? PW'(-sn_s3) : PW'(sn_s3);
		aden  = den_s3[PW-1] ? PW'(-den_s3) : PW'(den_s3);
		adx   = d1x_s3[DLW-1] ? DLW'(-d1x_s3) : DLW'(d1x_s3);
		ady   = d1y_s3[DLW-1] ? DLW'(-d1y_s3) : DLW'(d1y_s3);
		hit_c = (den_s3 != '0) &&
			(lines_s3 || (in_unit(tn_s3, den_s3) && in_unit(sn_s3, den_s3)));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s4  <= hit_c;
			negx_s4 <= sn_s3[PW-1] ^ d1x_s3[DLW-1] ^ den_s3[PW-1];
			negy_s4 <= sn_s3[PW-1] ^ d1y_s3[DLW-1] ^ den_s3[PW-1];
			ppxl_s4 <= asn[H-1:0] * adx;
			ppyl_s4 <= asn[H-1:0] * ady;
			ppxh_s4 <= asn[PW-1:H] * adx;
			ppyh_s4 <= asn[PW-1:H] * ady;
			aden_s4 <= aden[DW-1:0];
			ax_s4   <= ax_s3;
			ay_s4   <= ay_s3;
		end
	end

	// ---------------- stage 5: numerators ----------------
	logic          v_s5;
	ctl_t          ctl_s5;
	logic [NW-1:0] numx_s5, numy_s5;
	logic [DW-1:0] aden_s5;
	logic [CW-1:0] ax_s5, ay_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s5 <= NW'(ppxl_s4) + (NW'(ppxh_s4) << H);
			numy_s5 <= NW'(ppyl_s4) + (NW'(ppyh_s4) << H);
			ctl_s5  <= '{valid: v_s4, hit: hit_s4, neg_x: negx_s4, neg_y: negy_s4};
			aden_s5 <= aden_s4;
			ax_s5   <= ax_s4;
			ay_s5   <= ay_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// ---------------- divider chain ----------------
	ctl_t          ctl_c   [0:NW];
	logic [NW-1:0] numx_c  [0:NW];
	logic [NW-1:0] numy_c  [0:NW];
	logic [DW-1:0] remx_c  [0:NW];
	logic [DW-1:0] remy_c  [0:NW];
	logic [DW-1:0] den_c   [0:NW];
	logic [CW-1:0] stx_c   [0:NW];
	logic [CW-1:0] sty_c   [0:NW];

	always_comb begin
		ctl_c[0]       = ctl_s5;
		ctl_c[0].valid = v_s5;
		numx_c[0]      = numx_s5;
		numy_c[0]      = numy_s5;
		remx_c[0]      = '0;
		remy_c[0]      = '0;
		den_c[0]       = aden_s5;
		stx_c[0]       = ax_s5;
		sty_c[0]       = ay_s5;
	end

	for (genvar i = 0; i < NW; i++) begin : g_cell
		seg_isect_div_cell #(.NW(NW), .DW(DW), .CW(CW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.ctl_i    (ctl_c[i]),
			.num_x_i  (numx_c[i]),
			.num_y_i  (numy_c[i]),
			.rem_x_i  (remx_c[i]),
			.rem_y_i  (remy_c[i]),
			.den_i    (den_c[i]),
			.start_x_i(stx_c[i]),
			.start_y_i(sty_c[i]),
			.ctl_o    (ctl_c[i+1]),
			.num_x_o  (numx_c[i+1]),
			.num_y_o  (numy_c[i+1]),
			.rem_x_o  (remx_c[i+1]),
			.rem_y_o  (remy_c[i+1]),
			.den_o    (den_c[i+1]),
			.start_x_o(stx_c[i+1]),
			.start_y_o(sty_c[i+1])
		);
	end

	// ---------------- output register ----------------
	logic [CW-1:0] cx, cy;
	logic          out_valid_q, hit_q;
	logic [31:0]   cross_x_q, cross_y_q;
	ctl_t          last;

	assign last = ctl_c[NW];

	seg_isect_sat #(.NW(NW), .CW(CW)) u_sat_x (
		.neg  (last.neg_x),
		.quo  (numx_c[NW]),
		.start(stx_c[NW]),
		.coord(cx)
	);

	seg_isect_sat #(.NW(NW), .CW(CW)) u_sat_y (
		.neg  (last.neg_y),
		.quo  (numy_c[NW]),
		.start(sty_c[NW]),
		.coord(cy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q     <= last.hit;
			cross_x_q <= last.hit ? 32'($signed(cx)) : '0;
			cross_y_q <= last.hit ? 32'($signed(cy)) : '0;
		end
	end

	assign en           = !out_valid_q || out_ch.ready;
	assign in_ch.ready  = en;
	assign out_ch.valid = out_valid_q;
	assign out_ch.hit   = hit_q;
	assign out_ch.cross_x = cross_x_q;
	assign out_ch.cross_y = cross_y_q;

	// a miss always reports the origin
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.hit |-> out_ch.cross_x == '0 && out_ch.cross_y == '0)
		else $error("miss with nonzero point");

	// the pipeline only stalls on a held, untaken result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> out_ch.valid && !out_ch.ready)
		else $error("input stalled without output backpressure");

	// a stalled divider tail keeps its control bits
	a_tail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(last))
		else $error("divider tail moved during stall");

	// a zero divisor can never carry a hit into the chain
	a_den_hit: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && ctl_s5.hit |-> aden_s5 != '0)
		else $error("hit with zero cross product");
endmodule
`default_nettype wire

FILE: verif/segment_intersection_core_tb.sv
`timescale 1ns / 1ps
module segment_intersection_core_tb;

	localparam int LATENCY = 3 * 32 + 10;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic        hit;
		logic [31:0] px;
		logic [31:0] py;
	} isect_t;

	// Intersection predictor: exact 128-bit arithmetic, sign/magnitude range test,
	// truncating quotient and saturation to the 32-bit coordinate range.
	function automatic logic signed [127:0] abs128(logic signed [127:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic bit unit_range(logic signed [127:0] n, logic signed [127:0] d);
		if (d < 0) begin
			n = -n;
			d = -d;
		end
		return n >= 0 && n <= d;
	endfunction

	function automatic logic [31:0] axis_point(logic signed [63:0] start,
		logic signed [63:0] dir, logic signed [127:0] snum, logic signed [127:0] den);
		logic [127:0] mag;
		logic signed [127:0] q;
		logic signed [127:0] r;
		logic neg;
		mag = abs128(snum) * abs128(dir);
		mag = mag / abs128(den);
		neg = ((snum < 0) != (dir < 0)) != (den < 0);
		q = neg ? -$signed(mag) : $signed(mag);
		r = q + start;
		if (r > 128'sd2147483647)
			return 32'h7fffffff;
		if (r < -128'sd2147483648)
			return 32'h80000000;
		return r[31:0];
	endfunction

	function automatic isect_t predict_isect(logic [31:0] c[8], logic lines);
		logic signed [63:0] ax, ay, d1x, d1y, d2x, d2y, wx, wy;
		logic signed [127:0] den, sn, tn;
		isect_t res;
		res = '0;
		ax = $signed(c[0]);
		ay = $signed(c[1]);
		d1x = $signed(c[2]) - ax;
		d1y = $signed(c[3]) - ay;
		d2x = $signed(c[6]) - $signed(c[4]);
		d2y = $signed(c[7]) - $signed(c[5]);
		wx = ax - $signed(c[4]);
		wy = ay - $signed(c[5]);
		den = d1x * d2y - d1y * d2x;
		if (den == 0)
			return res;
		tn = wy * d1x - wx * d1y;
		sn = wy * d2x - wx * d2y;
		if (!lines && !(unit_range(tn, den) && unit_range(sn, den)))
			return res;
		res.hit = 1'b1;
		res.px = axis_point(ax, d1x, sn, den);
		res.py = axis_point(ay, d1y, sn, den);
		return res;
	endfunction

	class isect_scoreboard;
		isect_t pending[$];
		int mismatches;

		function void note_request(logic [31:0] c[8], logic lines);
			pending.push_back(predict_isect(c, lines));
		endfunction

		function void check_result(isect_t got);
			isect_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result hit=%0b x=%h y=%h", got.hit, got.px, got.py);
				return;
			end
			want = pending.pop_front();
			if (got.hit !== want.hit || got.px !== want.px || got.py !== want.py) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: want hit=%0b x=%h y=%h, got hit=%0b x=%h y=%h",
						want.hit, want.px, want.py, got.hit, got.px, got.py);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	seg_in_if in_ch();
	seg_out_if out_ch();
	isect_scoreboard board = new();

	// sender/receiver idle control
	bit calm = 0;        // no idling while set
	bit hold_rx = 0;     // long receiver hold-off
	longint cycles = 0;

	segment_intersection_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Watchdog: counts cycles, declares failure on overrun.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Result side: random ready, check every accepted result.
	initial out_ch.ready = 0;
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			board.check_result({out_ch.hit, out_ch.cross_x, out_ch.cross_y});
		out_ch.ready <= !hold_rx && (calm || $urandom_range(99) >= 32);
	end

	logic [31:0] coords[8];

	// Offer one request, with a random idle gap first; returns once accepted.
	// valid stays high on return; the next call or the caller drops it.
	task automatic send_request(logic [31:0] c[8], logic lines);
		while (!calm && $urandom_range(99) < 32) begin
			in_ch.valid <= 0;
			@(posedge clk);
		end
		in_ch.valid <= 1;
		{in_ch.first_start_x, in_ch.first_start_y, in_ch.first_end_x, in_ch.first_end_y}
			<= {c[0], c[1], c[2], c[3]};
		{in_ch.other_start_x, in_ch.other_start_y, in_ch.other_end_x, in_ch.other_end_y}
			<= {c[4], c[5], c[6], c[7]};
		in_ch.infinite_lines <= lines;
		do @(posedge clk); while (!in_ch.ready);
		board.note_request(c, lines);
	endtask

	task automatic send_pts(int ax, int ay, int bx, int by, int cx, int cy,
		int dx, int dy, logic lines);
		coords = '{ax, ay, bx, by, cx, cy, dx, dy};
		send_request(coords, lines);
	endtask

	// Random pair: mostly small grids, some full-range noise and near-limit values.
	task automatic send_random();
		int mode;
		mode = $urandom_range(9);
		for (int i = 0; i < 8; i++) begin
			if (mode < 5)
				coords[i] = $signed($urandom_range(2000)) - 1000 << 12;
			else if (mode < 7)
				coords[i] = $signed($urandom_range(20)) - 10;
			else if (mode < 9)
				coords[i] = $urandom();
			else
				coords[i] = $urandom_range(1) ? 32'h7fffffff - $urandom_range(3)
					: 32'h80000000 + $urandom_range(3);
		end
		// occasionally force parallel: second segment a shifted copy
		if ($urandom_range(15) == 0) begin
			coords[6] = coords[4] + (coords[2] - coords[0]);
			coords[7] = coords[5] + (coords[3] - coords[1]);
		end
		send_request(coords, $urandom_range(1));
	endtask

	task automatic drain();
		while (board.pending.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		in_ch.valid = 0;
		{in_ch.first_start_x, in_ch.first_start_y, in_ch.first_end_x, in_ch.first_end_y} = '0;
		{in_ch.other_start_x, in_ch.other_start_y, in_ch.other_end_x, in_ch.other_end_y} = '0;
		in_ch.infinite_lines = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: plain crossing, endpoint touches, miss, parallel, zero length.
		send_pts(0, 0, 4 << 16, 4 << 16, 0, 4 << 16, 4 << 16, 0, 0);
		send_pts(0, 0, 2 << 16, 0, 2 << 16, 0, 2 << 16, 5 << 16, 0);   // end touch
		send_pts(0, 0, 2 << 16, 0, 0, 0, 0, 5 << 16, 0);               // start touch
		send_pts(0, 0, 1 << 16, 0, 3 << 16, -1, 3 << 16, 1, 0);        // miss
		send_pts(0, 0, 1 << 16, 0, 3 << 16, -1, 3 << 16, 1, 1);        // line mode hit
		send_pts(0, 0, 1, 1, 5, 0, 6, 1, 1);                           // parallel
		send_pts(7, 7, 7, 7, 0, 0, 9, 3, 1);                           // zero length
		send_pts(0, 0, 1, 0, 32'h7fffffff, -1, 32'h7fffffff, 1, 0);
		// far points in line mode, one in each x direction
		send_pts(0, 0, 1, 1, 32'h7fffffff, 0, 32'h7ffffffe, 1, 1);
		send_pts(0, 0, 1, 0, 32'h80000000, 0, 32'h80000000, 1, 1);
		send_pts(0, 0, 1, 1, 0, 1, 1, 3, 1);
		send_pts(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0);
		send_pts(-1, -1, -1, -1, -1, -1, -1, -1, 0);
		send_pts(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 1);

		// Sender pause until all results are back.
		in_ch.valid <= 0;
		drain();

		// Receiver hold-off while the sender keeps offering: pipeline fills.
		fork
			begin
				hold_rx = 1;
				repeat (300) @(posedge clk);
				hold_rx = 0;
			end
			begin
				calm = 1;
				repeat (150) send_random();
				calm = 0;
			end
		join

		for (int n = 0; n < 1100; n++) begin
			calm = (n >= 400 && n < 600);
			send_random();
		end
		calm = 0;
		in_ch.valid <= 0;

		fork
			drain();
			repeat (LATENCY * 4 + 20000) @(posedge clk);
		join_any
		disable fork;
		repeat (LATENCY + 10) @(posedge clk);
		if (board.pending.size() == 0 && board.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
